FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

FILE: rtl/core/lcasc_pkg.sv
// Shared types and constants of the load-cell averaging block.
package lcasc_pkg;
    localparam int WindowLen = 8;
    localparam int SlotW = $clog2(WindowLen);
    localparam int SumW = 20 + SlotW;
    localparam logic [19:0] GramsMax = 20'hFFFFF;

    localparam logic [2:0] RegTare = 3'd0;
    localparam logic [2:0] RegCpk = 3'd1;
    localparam logic [2:0] RegStab = 3'd2;
    localparam logic [2:0] RegUnit = 3'd3;
    localparam logic [2:0] RegZero = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GRAMS, ST_GDIV, ST_STORE, ST_SUM, ST_MEAN,
        ST_DEV, ST_CDIV, ST_DONE, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic gdiv_start;
        logic store;
        logic sum_step;
        logic mean;
        logic dev_step;
        logic cdiv_start;
        logic finish;
        logic clr_idx;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic idx_last;
    } sts_t;
endpackage

FILE: rtl/core/lcasc_div.sv
// Restoring divider, one quotient bit per cycle, 40 by 24 bits.
module lcasc_div import lcasc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [23:0] divisor,
    output logic        busy,
    output logic [39:0] quotient
);
    logic [39:0] q_reg, q_next;
    logic [24:0] r_reg, r_next;
    logic [23:0] d_reg, d_next;
    logic [5:0]  n_reg, n_next;
    logic [24:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        trial = {r_reg[23:0], q_reg[39]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            n_next = 6'd40;
        end
        else if (n_reg != 6'd0)
        begin
            n_next = n_reg - 6'd1;
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[38:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= '0;
        else
            n_reg <= n_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (n_reg != 6'd0);
    assign quotient = q_reg;
endmodule

FILE: rtl/core/lcasc_datapath.sv
// Datapath: registers, ring, accumulators and shared divider.
module lcasc_datapath import lcasc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic [23:0] raw_sample,
    output logic [19:0] mean_grams,
    output logic [19:0] item_count,
    output logic        steady
);
    logic [23:0] tare_reg, cpk_reg;
    logic [19:0] stab_reg, unit_reg, zero_reg;
    logic [19:0] ring_reg [WindowLen];
    logic [SlotW-1:0] slot_reg, idx_reg;
    logic [24:0] diff_reg;
    logic [19:0] grams_reg, mean_reg, worst_reg, rd;
    logic [SumW-1:0] sum_reg;
    logic [19:0] om_reg, oc_reg;
    logic os_reg;
    logic [39:0] dvd, quo;
    logic [23:0] dvs;
    logic dbusy;
    logic [19:0] dev;
    logic [35:0] prod;
    logic [19:0] gval;

    lcasc_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.gdiv_start | cmd.cdiv_start),
        .dividend(dvd), .divisor(dvs), .busy(dbusy), .quotient(quo));

    assign prod = {11'd0, diff_reg} * 36'd1000;
    assign dvd = cmd.cdiv_start ? {20'd0, mean_reg} : {4'd0, prod};
    assign dvs = cmd.cdiv_start ? {4'd0, unit_reg} : cpk_reg;
    assign rd = ring_reg[idx_reg];
    assign dev = (rd > mean_reg) ? rd - mean_reg : mean_reg - rd;
    assign sts.div_busy = dbusy;
    assign sts.idx_last = (idx_reg == SlotW'(WindowLen - 1));
    assign gval = (diff_reg[24] || diff_reg == '0 || cpk_reg == '0) ? grams_reg :
                  ((quo > {20'd0, GramsMax}) ? GramsMax : quo[19:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg <= '0;
            cpk_reg <= 24'd1;
            stab_reg <= 20'd50;
            unit_reg <= 20'd500;
            zero_reg <= 20'd50;
            slot_reg <= '0;
            for (int i = 0; i < WindowLen; i++)
                ring_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegTare: tare_reg <= cfg_data;
                    RegCpk: cpk_reg <= cfg_data;
                    RegStab: stab_reg <= cfg_data[19:0];
                    RegUnit: unit_reg <= cfg_data[19:0];
                    RegZero: zero_reg <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (cmd.store)
            begin
                ring_reg[slot_reg] <= gval;
                slot_reg <= (slot_reg == SlotW'(WindowLen - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            diff_reg <= {raw_sample[23], raw_sample} - {tare_reg[23], tare_reg};
        if (cmd.gdiv_start)
        begin
            if (diff_reg[24] || diff_reg == '0)
                grams_reg <= '0;
            else if (cpk_reg == '0)
                grams_reg <= GramsMax;
        end
        if (cmd.clr_idx)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            worst_reg <= '0;
        end
        if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + SumW'(rd);
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.mean)
            mean_reg <= sum_reg[SumW-1:SlotW];
        if (cmd.dev_step)
        begin
            if (dev > worst_reg)
                worst_reg <= dev;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            os_reg <= (worst_reg < stab_reg);
            if (mean_reg > zero_reg)
            begin
                om_reg <= mean_reg;
                oc_reg <= (unit_reg == '0) ? GramsMax : quo[19:0];
            end
            else
            begin
                om_reg <= '0;
                oc_reg <= '0;
            end
        end
    end

    assign mean_grams = om_reg;
    assign item_count = oc_reg;
    assign steady = os_reg;
endmodule

FILE: rtl/core/lcasc_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module lcasc_ctrl import lcasc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_GRAMS;
                end
            end
            ST_GRAMS:
            begin
                cmd.gdiv_start = 1'b1;
                state_next = ST_GDIV;
            end
            ST_GDIV:
                if (!sts.div_busy)
                    state_next = ST_STORE;
            ST_STORE:
            begin
                cmd.store = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.clr_idx = 1'b1;
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                cmd.sum_step = 1'b1;
                if (sts.idx_last)
                    state_next = ST_DEV;
            end
            ST_DEV:
            begin
                cmd.mean = 1'b1;
                cmd.clr_idx = 1'b1;
                state_next = ST_CDIV;
            end
            ST_CDIV:
            begin
                cmd.dev_step = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.cdiv_start = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
                if (!sts.div_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_ready = out_ready;
                if (out_ready)
                    state_next = ST_IDLE;
                if (out_ready && in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_GRAMS;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/load_cell_average_stability_count_top.sv
// Top level of the load-cell moving average, stability and counting block.
// Channel | signals                                  | direction
// input   | in_valid, in_ready, raw_sample           | item in
// output  | out_valid, out_ready, mean/count/steady  | item out
// Each item is processed by two divider passes and two walks over the eight ring slots,
// with control states between them, before the next item can be accepted.
// Reset clears the configuration to its defaults and the sample ring to zero.
// A finished item is held on the output until taken; a new item can be taken in the same cycle.
module load_cell_average_stability_count_top import lcasc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] raw_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [19:0] mean_grams,
    output logic [19:0] item_count,
    output logic        steady
);
    cmd_t cmd;
    sts_t sts;

    lcasc_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    lcasc_datapath u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .raw_sample(raw_sample),
        .mean_grams(mean_grams), .item_count(item_count), .steady(steady));
endmodule

FILE: rtl/core/lcasc_checker.sv
// Port-level checker for the load-cell block, with its bind.
`include "assert_macros.svh"
module lcasc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [19:0] mean_grams,
    input logic [19:0] item_count
);
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mean_grams))
    `CHK_IMPLY(a_zero_cnt, clk, rst_n, out_valid && mean_grams == 20'd0, item_count == 20'd0)
    `CHK_NEXT(a_no_out_after_take, clk, rst_n, in_valid && in_ready, !out_valid)
    `CHK_IMPLY(a_ready_out, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind load_cell_average_stability_count_top lcasc_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .mean_grams(mean_grams), .item_count(item_count));

FILE: verif/testbench.sv
// Testbench for the load-cell averaging block, checked against a predictor.
module testbench import lcasc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [19:0] mean_grams;
        logic [19:0] item_count;
        logic        steady;
    } weigh_t;

    class weigh_board;
        logic [23:0] tare;
        logic [23:0] cpk;
        logic [19:0] stab;
        logic [19:0] unit_w;
        logic [19:0] zband;
        logic [19:0] ring [WindowLen];
        int slot;
        weigh_t pending [$];
        int errors;

        function new();
            tare = 0;
            cpk = 1;
            stab = 50;
            unit_w = 500;
            zband = 50;
            foreach (ring[i]) ring[i] = 0;
            slot = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                RegTare: tare = val;
                RegCpk: cpk = val;
                RegStab: stab = val[19:0];
                RegUnit: unit_w = val[19:0];
                RegZero: zband = val[19:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [23:0] raw);
            longint diff;
            longint q;
            longint sum;
            logic [19:0] g;
            logic [19:0] avg;
            logic [19:0] worst;
            logic [19:0] d;
            weigh_t r;
            diff = longint'($signed(raw)) - longint'($signed(tare));
            if (diff <= 0) g = 0;
            else if (cpk == 0) g = GramsMax;
            else
            begin
                q = (diff * 1000) / longint'(cpk);
                g = (q > 1048575) ? GramsMax : q[19:0];
            end
            ring[slot] = g;
            slot = (slot + 1) % WindowLen;
            sum = 0;
            foreach (ring[i]) sum += ring[i];
            avg = 20'(sum / WindowLen);
            worst = 0;
            foreach (ring[i])
            begin
                d = (ring[i] > avg) ? ring[i] - avg : avg - ring[i];
                if (d > worst) worst = d;
            end
            r.steady = worst < stab;
            if (avg > zband)
            begin
                r.mean_grams = avg;
                r.item_count = (unit_w == 0) ? GramsMax : avg / unit_w;
            end
            else
            begin
                r.mean_grams = 0;
                r.item_count = 0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [19:0] m, logic [19:0] c, logic s);
            weigh_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (m !== e.mean_grams)
            begin
                $error("mean_grams expected %0d actual %0d", e.mean_grams, m);
                errors++;
            end
            if (c !== e.item_count)
            begin
                $error("item_count expected %0d actual %0d", e.item_count, c);
                errors++;
            end
            if (s !== e.steady)
            begin
                $error("steady expected %0d actual %0d", e.steady, s);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [23:0] raw_sample = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [19:0] mean_grams;
    logic [19:0] item_count;
    logic steady;
    weigh_board board;
    int cycles = 0;
    bit quiet = 0;

    load_cell_average_stability_count_top uut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
            board.check_result(mean_grams, item_count, steady);
    end

    always @(negedge clk)
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic send_sample(logic [23:0] raw);
        if (!quiet)
            while ($urandom_range(99) < 37) @(negedge clk);
        in_valid = 1;
        raw_sample = raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_sample(raw);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic set_all(logic [23:0] t, logic [23:0] c, logic [19:0] s,
                           logic [19:0] u, logic [19:0] z);
        write_reg(RegTare, t);
        write_reg(RegCpk, c);
        write_reg(RegStab, s);
        write_reg(RegUnit, u);
        write_reg(RegZero, z);
    endtask

    initial
    begin
        logic [23:0] base;
        board = new();
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'd0);
        send_sample(24'd3000);
        drain();
        set_all(24'h800000, 24'd0, 20'd0, 20'd0, 20'd0);
        write_reg(3'd7, 24'hFFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h800001);
        send_sample(24'd5);
        drain();
        set_all(24'h7FFFFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        drain();
        set_all(24'd1000, 24'd2000, 20'd40, 20'd250, 20'd10);
        for (int i = 0; i < 10; i++) send_sample(24'(1000 + i * 400));
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_all(24'($urandom), 24'($urandom_range(1, 16000)), 20'($urandom_range(0, 300)),
                    20'($urandom_range(0, 2000)), 20'($urandom_range(0, 200)));
            if (ph == 7) write_reg(RegCpk, 24'($urandom));
            quiet = (ph == 3);
            base = 24'(board.tare + $urandom_range(0, 20000));
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(9) < 8)
                    send_sample(24'(base + $urandom_range(0, 60) - 30));
                else
                    send_sample(24'($urandom));
                if (i == 50) drain();
            end
            drain();
        end
        quiet = 0;
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lcasc_pkg.sv
rtl/core/lcasc_div.sv
rtl/core/lcasc_datapath.sv
rtl/core/lcasc_ctrl.sv
rtl/core/load_cell_average_stability_count_top.sv
rtl/core/lcasc_checker.sv
verif/testbench.sv
